// ----- sv/icf_pkg.sv -----
// Shared types and constants of the image convolution filter.
`default_nettype none

package icf_pkg;

  localparam int CHANNELS   = 3;
  localparam int CH_W       = 8;
  localparam int FRAC_W     = 8;
  localparam int MAX_RADIUS = 2;
  localparam int WIN        = 2 * MAX_RADIUS + 1;
  localparam int LINES      = 2 * MAX_RADIUS;
  localparam int LINE_W     = $clog2(LINES);
  localparam int WIN_IDX_W  = $clog2(WIN);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int RAD_W      = 2;
  localparam int W_BITS     = 12;
  localparam int NUM_WROWS  = 5;
  localparam int PROD_W     = 20;
  localparam int RSUM_W     = 23;
  localparam int SUM_W      = 25;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;

  // Q4.8 unity weight
  localparam logic [W_BITS-1:0] W_ONE = 12'd256;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_RADIUS = 3'd2,
    REG_WEIGHT_ROW0   = 3'd3,
    REG_WEIGHT_ROW1   = 3'd4,
    REG_WEIGHT_ROW2   = 3'd5,
    REG_WEIGHT_ROW3   = 3'd6,
    REG_WEIGHT_ROW4   = 3'd7
  } reg_idx_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] pix_t;
  // one kernel row: five Q4.8 weights, column j at bits 12j
  typedef logic [NUM_WROWS-1:0][W_BITS-1:0] wrow_t;

  typedef struct packed {
    logic              valid;
    logic [LINE_W-1:0] line;    // line slot of the incoming pixel's row
    logic [RAD_W-1:0]  radius;
  } conv_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    pix_t                 chan;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/icf_line_buf.sv -----
// Line store: one memory row per column holding that column of the last four lines.
`default_nettype none

module icf_line_buf import icf_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     acc,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [LINE_W-1:0]        line,
  input  wire pix_t                     wdata,
  output pix_t      [LINES-1:0]         rdata,
  output logic                          busy
);

  localparam int AW = $clog2(DEPTH);

  pix_t [LINES-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  // clearing sweep after reset, one row a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  // read returns the old contents: lines r-1 to r-4 at this column
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (acc) begin
      mem[addr][line] <= wdata;
      rdata           <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/icf_conv.sv -----
// Window registers, per-tap product stage, row sums and final sum with clamp.
`default_nettype none

module icf_conv import icf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire conv_ctl_t               ctl,
  input  wire pix_t                    pix,
  input  wire pix_t  [LINES-1:0]       line_pix,
  input  wire wrow_t [NUM_WROWS-1:0]   weights,
  output logic                         res_valid,
  output pix_t                         res_pix
);

  pix_t                     win      [WIN][WIN];
  pix_t                     win_next [WIN][WIN];
  pix_t                     col_new  [WIN];
  logic signed [W_BITS-1:0] wpos     [WIN][WIN];
  logic signed [PROD_W-1:0] prod     [CHANNELS][WIN][WIN];
  logic signed [RSUM_W-1:0] rsum_next [CHANNELS][WIN];
  logic signed [RSUM_W-1:0] rsum     [CHANNELS][WIN];
  logic signed [SUM_W-1:0]  total    [CHANNELS];
  logic [WIN_IDX_W-1:0]     base;
  logic                     v2;
  logic                     v3;

  function automatic chan_t clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0] t;
    t = s[SUM_W-1:FRAC_W];
    if (s <= 0) return '0;
    if (t > {{(SUM_W-FRAC_W-CH_W){1'b0}}, {CH_W{1'b1}}}) return '1;
    return t[CH_W-1:0];
  endfunction

  // new window column: newest pixel at the bottom, older lines above
  always_comb begin
    col_new[WIN-1] = pix;
    for (int d = 1; d <= LINES; d++) begin
      col_new[WIN-1-d] = line_pix[LINE_W'(ctl.line - LINE_W'(d))];
    end
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_next[k][j] = win[k][j+1];
      end
      win_next[k][WIN-1] = col_new[k];
    end
  end

  // kernel sits in the lower right corner of the window
  assign base = WIN_IDX_W'(WIN - 1) - {ctl.radius, 1'b0};

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN; j++) begin
        if (WIN_IDX_W'(k) >= base && WIN_IDX_W'(j) >= base) begin
          wpos[k][j] = $signed(weights[WIN_IDX_W'(k) - base][WIN_IDX_W'(j) - base]);
        end else begin
          wpos[k][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= ctl.valid;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      win <= win_next;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < WIN; k++) begin
          for (int j = 0; j < WIN; j++) begin
            prod[c][k][j] <= PROD_W'($signed({1'b0, win_next[k][j][c]}) * wpos[k][j]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WIN; k++) begin
        rsum_next[c][k] = '0;
        for (int j = 0; j < WIN; j++) begin
          rsum_next[c][k] = rsum_next[c][k] + RSUM_W'(prod[c][k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2) rsum <= rsum_next;
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      total[c] = '0;
      for (int k = 0; k < WIN; k++) begin
        total[c] = total[c] + SUM_W'(rsum[c][k]);
      end
      res_pix[c] = clamp_chan(total[c]);
    end
  end

  assign res_valid = v3;

endmodule

`default_nettype wire

// ----- sv/image_convolution_filter.sv -----
// Top level of the streaming 5x5 three-channel image convolution filter.
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------------
//  input     in_valid/in_ready    chan0_in, chan1_in, chan2_in (raster order)
//  output    out_valid/out_ready  out_row, out_col, chan0..2_out, last_of_run
//  config    APB psel/penable     paddr (8 bytes per register), pwdata, prdata
//
//  One pixel transfer per clock while in_ready is high. A pixel's results pass
//  the line store read, the product stage and the row sum stage into the queue.
//  After reset a clearing pass over the line store runs with in_ready low;
//  configuration writes are taken during it. in_ready drops during that pass and
//  when the result queue cannot take the results already in flight plus two more;
//  a stall on the output side backs up into the queue.
`default_nettype none

module image_convolution_filter import icf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  // pixel input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CH_W-1:0]   chan0_in,
  input  wire logic [CH_W-1:0]   chan1_in,
  input  wire logic [CH_W-1:0]   chan2_in,
  // result output
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ROW_W-1:0]       out_row,
  output logic [OUT_COL_W-1:0]   out_col,
  output logic [CH_W-1:0]        chan0_out,
  output logic [CH_W-1:0]        chan1_out,
  output logic [CH_W-1:0]        chan2_out,
  output logic                   last_of_run
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             border;
  } meta_t;

  // configuration registers
  logic [FW_W-1:0]               frame_width;
  logic [FH_W-1:0]               frame_height;
  logic [RAD_W-1:0]              kernel_radius;
  wrow_t [NUM_WROWS-1:0]         weight_row;
  reg_idx_t                      cfg_idx;
  logic                          cfg_wr;

  // effective geometry
  logic [WEFF_W-1:0]             w_eff;
  logic [FH_W-1:0]               h_eff;
  logic [RAD_W-1:0]              r_eff;
  logic [RAD_W:0]                r_twice;

  // position
  logic [COL_W-1:0]              col_count;
  logic [ROW_W-1:0]              row_count;
  logic [COL_W-1:0]              cur_col;
  logic [ROW_W-1:0]              cur_row;
  logic [ROW_W:0]                row_tmp;
  logic [WEFF_W-1:0]             col_inc;
  logic [ROW_W:0]                row_inc;
  logic [COL_W-1:0]              col_count_next;
  logic [ROW_W-1:0]              row_count_next;
  logic                          cur_interior;
  logic                          cur_border;
  logic [1:0]                    n_acc;
  logic                          in_acc;
  pix_t                          in_pix;

  // pipeline
  pix_t                          s1_pix;
  meta_t                         meta   [3];
  logic                          meta_v [3];
  pix_t  [LINES-1:0]             lb_rdata;
  logic                          lb_busy;
  conv_ctl_t                     conv_ctl;
  logic                          conv_valid;
  pix_t                          conv_pix;

  // result queue
  result_t                       fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]            wr_ptr;
  logic [FIFO_AW-1:0]            rd_ptr;
  logic [CNT_W-1:0]              fifo_count;
  logic [CNT_W-1:0]              pending;
  logic [1:0]                    n_wr;
  logic                          pop;
  result_t                       res_int;
  result_t                       res_bord;

  // ---------------------------------------------------------------------------
  // Configuration port. Zero-wait, registers at 8-byte strides.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(1024);
      frame_height  <= FH_W'(4096);
      kernel_radius <= RAD_W'(1);
      weight_row    <= '0;
      weight_row[1][1] <= W_ONE;     // identity kernel for radius 1
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:   frame_width   <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[FH_W-1:0];
        REG_KERNEL_RADIUS: kernel_radius <= pwdata[RAD_W-1:0];
        REG_WEIGHT_ROW0:   weight_row[0] <= pwdata[$bits(wrow_t)-1:0];
        REG_WEIGHT_ROW1:   weight_row[1] <= pwdata[$bits(wrow_t)-1:0];
        REG_WEIGHT_ROW2:   weight_row[2] <= pwdata[$bits(wrow_t)-1:0];
        REG_WEIGHT_ROW3:   weight_row[3] <= pwdata[$bits(wrow_t)-1:0];
        REG_WEIGHT_ROW4:   weight_row[4] <= pwdata[$bits(wrow_t)-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:   prdata = CFG_DW'(frame_width);
      REG_FRAME_HEIGHT:  prdata = CFG_DW'(frame_height);
      REG_KERNEL_RADIUS: prdata = CFG_DW'(kernel_radius);
      REG_WEIGHT_ROW0:   prdata = CFG_DW'(weight_row[0]);
      REG_WEIGHT_ROW1:   prdata = CFG_DW'(weight_row[1]);
      REG_WEIGHT_ROW2:   prdata = CFG_DW'(weight_row[2]);
      REG_WEIGHT_ROW3:   prdata = CFG_DW'(weight_row[3]);
      REG_WEIGHT_ROW4:   prdata = CFG_DW'(weight_row[4]);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective geometry: zero size acts as one, oversize clips to the maximum.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (frame_width == '0)                   w_eff = WEFF_W'(1);
    else if (32'(frame_width) > MAX_WIDTH)   w_eff = WEFF_W'(MAX_WIDTH);
    else                                     w_eff = WEFF_W'(frame_width);

    if (frame_height == '0)                  h_eff = FH_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = FH_W'(MAX_HEIGHT);
    else                                     h_eff = frame_height;

    if (32'(kernel_radius) > MAX_RADIUS)     r_eff = RAD_W'(MAX_RADIUS);
    else                                     r_eff = kernel_radius;
  end

  assign r_twice = {r_eff, 1'b0};

  // ---------------------------------------------------------------------------
  // Position of the incoming pixel. The stored position can sit outside the
  // frame only after a resize; it then wraps before the pixel is taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (WEFF_W'(col_count) >= w_eff) begin
      cur_col = '0;
      row_tmp = {1'b0, row_count} + 1'b1;
    end else begin
      cur_col = col_count;
      row_tmp = {1'b0, row_count};
    end
    cur_row = (row_tmp >= (ROW_W+1)'(h_eff)) ? '0 : row_tmp[ROW_W-1:0];

    col_inc = WEFF_W'(cur_col) + 1'b1;
    row_inc = {1'b0, cur_row} + 1'b1;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= (ROW_W+1)'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = cur_row;
    end

    // the window of (r-R, c-R) completes with this pixel
    cur_interior = (cur_row >= ROW_W'(r_twice)) && (cur_col >= COL_W'(r_twice));
    cur_border   = (cur_row < ROW_W'(r_eff))
                || (({1'b0, cur_row} + (ROW_W+1)'(r_eff)) >= (ROW_W+1)'(h_eff))
                || (cur_col < COL_W'(r_eff))
                || (((WEFF_W+1)'(cur_col) + (WEFF_W+1)'(r_eff)) >= (WEFF_W+1)'(w_eff));
    n_acc = {1'b0, cur_interior} + {1'b0, cur_border};
  end

  assign in_pix   = {chan2_in, chan1_in, chan0_in};
  // reserve queue room for everything already in flight plus two more
  assign in_ready = !lb_busy && (pending <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline: transfer -> line store read / s1 -> products -> row sums -> queue
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_v[0] <= 1'b0;
      meta_v[1] <= 1'b0;
      meta_v[2] <= 1'b0;
    end else begin
      meta_v[0] <= in_acc;
      meta_v[1] <= meta_v[0];
      meta_v[2] <= meta_v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix           <= in_pix;
      meta[0].row      <= cur_row;
      meta[0].col      <= cur_col;
      meta[0].interior <= cur_interior;
      meta[0].border   <= cur_border;
    end
    meta[1] <= meta[0];
    meta[2] <= meta[1];
  end

  icf_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .rst   (rst),
    .acc   (in_acc),
    .addr  (cur_col),
    .line  (cur_row[LINE_W-1:0]),
    .wdata (in_pix),
    .rdata (lb_rdata),
    .busy  (lb_busy)
  );

  assign conv_ctl.valid  = meta_v[0];
  assign conv_ctl.line   = meta[0].row[LINE_W-1:0];
  assign conv_ctl.radius = r_eff;

  icf_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .ctl       (conv_ctl),
    .pix       (s1_pix),
    .line_pix  (lb_rdata),
    .weights   (weight_row),
    .res_valid (conv_valid),
    .res_pix   (conv_pix)
  );

  // ---------------------------------------------------------------------------
  // Result queue. An interior result goes first, the border result after it.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_int.row   = meta[2].row - ROW_W'(r_eff);
    res_int.col   = OUT_COL_W'(meta[2].col - COL_W'(r_eff));
    res_int.chan  = conv_pix;
    res_int.last  = !meta[2].border;

    res_bord.row  = meta[2].row;
    res_bord.col  = OUT_COL_W'(meta[2].col);
    res_bord.chan = '0;
    res_bord.last = 1'b1;

    n_wr = meta_v[2] ? ({1'b0, meta[2].interior} + {1'b0, meta[2].border}) : 2'd0;
  end

  assign out_valid = (fifo_count != '0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (meta_v[2]) begin
      if (meta[2].interior) begin
        fifo[wr_ptr] <= res_int;
        if (meta[2].border) fifo[FIFO_AW'(wr_ptr + 1'b1)] <= res_bord;
      end else if (meta[2].border) begin
        fifo[wr_ptr] <= res_bord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pending    <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(n_wr);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count + CNT_W'(n_wr) - CNT_W'(pop);
      pending    <= pending + (in_acc ? CNT_W'(n_acc) : '0) - CNT_W'(pop);
    end
  end

  assign out_row     = fifo[rd_ptr].row;
  assign out_col     = fifo[rd_ptr].col;
  assign chan0_out   = fifo[rd_ptr].chan[0];
  assign chan1_out   = fifo[rd_ptr].chan[1];
  assign chan2_out   = fifo[rd_ptr].chan[2];
  assign last_of_run = fifo[rd_ptr].last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("result queue holds more than was reserved");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(FIFO_DEPTH))
    else $error("reserved results exceed queue depth");

  a_conv_aligned: assert property (@(posedge clk) disable iff (rst)
    conv_valid == meta_v[2])
    else $error("convolution result out of step with position pipeline");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && (col_inc == w_eff) |=> (col_count == '0))
    else $error("column did not wrap after last pixel of a row");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the streaming 5x5 image convolution filter.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icf_pkg::*;

  localparam int MAX_W = 1024;
  // The block emits through registered stages after a transfer; allow a margin on top.
  localparam int SETTLE = 8;
  localparam int RANDOM_ITEMS = 1080;
  localparam int SCRIPT_LEN = 31;

  // Traffic shapes for the handshakes.
  typedef enum logic [1:0] {
    LOAD_NONE,
    LOAD_SENDER,
    LOAD_RECEIVER,
    LOAD_BOTH
  } load_mode_e;

  typedef enum logic {
    STEP_PIXEL,
    STEP_WRITE
  } step_e;

  // One row of the directed script: either a register write or a pixel.
  // Pixel rows with 'typed' set carry their single result spelled out.
  typedef struct packed {
    step_e             kind;
    reg_idx_t          idx;
    logic [CFG_DW-1:0] data;
    pix_t              pix;
    logic              typed;
    result_t           want;
  } script_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [CFG_AW-1:0]    paddr     = '0;
  logic [CFG_DW-1:0]    pwdata    = '0;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      chan0_in  = '0;
  logic [CH_W-1:0]      chan1_in  = '0;
  logic [CH_W-1:0]      chan2_in  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic [CH_W-1:0]      chan0_out;
  logic [CH_W-1:0]      chan1_out;
  logic [CH_W-1:0]      chan2_out;
  logic                 last_of_run;

  image_convolution_filter #(.MAX_WIDTH(MAX_W)) uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .chan0_in    (chan0_in),
    .chan1_in    (chan1_in),
    .chan2_in    (chan2_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .chan0_out   (chan0_out),
    .chan1_out   (chan1_out),
    .chan2_out   (chan2_out),
    .last_of_run (last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the filter: register values, line store, window, position.
  // Everything the block keeps is mirrored here and stepped once per pixel.
  // ---------------------------------------------------------------------------
  int unsigned cfg_width  = 1024;
  int unsigned cfg_height = 4096;
  int unsigned cfg_radius = 1;
  wrow_t       cfg_wrows [NUM_WROWS];
  pix_t        line_copy [LINES][MAX_W];
  pix_t        win_copy  [WIN][WIN];
  int unsigned next_col   = 0;
  int unsigned next_row   = 0;

  // Results still owed by the block, oldest first.
  result_t     pending_outputs [$];
  int          errors = 0;
  load_mode_e  load_mode = LOAD_NONE;

  // Directed script. Starts from the reset geometry (1024 x 4096, radius 1,
  // identity kernel), then walks a 3x3 frame, a radius 0 kernel at its weight
  // extremes, out of range geometry, and resizes that land mid-frame.
  script_row_t script_tab [SCRIPT_LEN] = '{
    // reset geometry: top row is border, so each pixel echoes a zero result
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFF00FF, 1'b1,
      '{12'd0, 10'd0, 24'h000000, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h00FF00, 1'b1,
      '{12'd0, 10'd1, 24'h000000, 1'b1}},
    // 3x3 frame with the 3x3 identity: only the centre pixel is interior
    '{STEP_WRITE, REG_FRAME_WIDTH,   64'd3,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h123456, 1'b1,
      '{12'd0, 10'd2, 24'h000000, 1'b1}},
    '{STEP_WRITE, REG_FRAME_HEIGHT,  64'd3,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h010203, 1'b1,
      '{12'd1, 10'd0, 24'h000000, 1'b1}},
    // centre pixel: nothing comes out until its window closes
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h807F01, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFEDCBA, 1'b1,
      '{12'd1, 10'd2, 24'h000000, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h00FFFF, 1'b1,
      '{12'd2, 10'd0, 24'h000000, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFF0000, 1'b1,
      '{12'd2, 10'd1, 24'h000000, 1'b1}},
    // closes the centre window: interior result, then the corner border
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h55AA55, 1'b0, '0},
    // radius 0, largest positive weight: 8x gain, clamps at 255
    '{STEP_WRITE, REG_KERNEL_RADIUS, 64'd0,    24'h0,      1'b0, '0},
    '{STEP_WRITE, REG_WEIGHT_ROW0,   64'h7FF,  24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFF0100, 1'b1,
      '{12'd0, 10'd0, 24'hFF0700, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h101010, 1'b1,
      '{12'd0, 10'd1, 24'h7F7F7F, 1'b1}},
    // most negative weight: every sum goes below zero
    '{STEP_WRITE, REG_WEIGHT_ROW0,   64'h800,  24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFFFFFF, 1'b1,
      '{12'd0, 10'd2, 24'h000000, 1'b1}},
    // zero width and height act as a 1x1 frame; unity weight passes through
    '{STEP_WRITE, REG_WEIGHT_ROW0,   64'h100,  24'h0,      1'b0, '0},
    '{STEP_WRITE, REG_FRAME_WIDTH,   64'd0,    24'h0,      1'b0, '0},
    '{STEP_WRITE, REG_FRAME_HEIGHT,  64'd0,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hABCDEF, 1'b1,
      '{12'd0, 10'd0, 24'hABCDEF, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h0055AA, 1'b1,
      '{12'd0, 10'd0, 24'h0055AA, 1'b1}},
    // oversized geometry and radius saturate at their maxima
    '{STEP_WRITE, REG_FRAME_WIDTH,   64'd2047, 24'h0,      1'b0, '0},
    '{STEP_WRITE, REG_FRAME_HEIGHT,  64'd8191, 24'h0,      1'b0, '0},
    '{STEP_WRITE, REG_KERNEL_RADIUS, 64'd3,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h000000, 1'b1,
      '{12'd0, 10'd0, 24'h000000, 1'b1}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'hFFFFFF, 1'b1,
      '{12'd0, 10'd1, 24'h000000, 1'b1}},
    // shrink below the current column: wraps to the next row
    '{STEP_WRITE, REG_FRAME_WIDTH,   64'd2,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h7F8081, 1'b1,
      '{12'd1, 10'd0, 24'h000000, 1'b1}},
    // shrink below the current row: wraps to row 0; frame smaller than kernel
    '{STEP_WRITE, REG_FRAME_HEIGHT,  64'd1,    24'h0,      1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,   64'd0,    24'h818080, 1'b1,
      '{12'd0, 10'd1, 24'h000000, 1'b1}}
  };

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (clearing pass included).
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Steps the shadow filter by one pixel and queues the results it owes.
  function automatic void filter_pixel(pix_t p);
    int unsigned w, h, rad, r, c, base;
    int          acc;
    int          n;
    result_t     made [2];
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    rad = (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
    n = 0;
    // a resize may have left the position outside the frame
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    r = next_row;
    c = next_col;
    // slide the window left and pull the new column from the line store
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN - 1; j++) win_copy[k][j] = win_copy[k][j+1];
    end
    for (int d = 1; d <= LINES; d++) begin
      win_copy[WIN-1-d][WIN-1] = line_copy[(r % LINES + LINES - d) % LINES][c];
    end
    win_copy[WIN-1][WIN-1] = p;
    line_copy[r % LINES][c] = p;
    // window centred on (r-rad, c-rad) is complete
    if (r >= 2 * rad && c >= 2 * rad) begin
      base = WIN - 1 - 2 * rad;
      made[n] = '0;
      for (int q = 0; q < CHANNELS; q++) begin
        acc = 0;
        for (int a = 0; a <= 2 * rad; a++) begin
          for (int b = 0; b <= 2 * rad; b++) begin
            acc += int'(win_copy[base+a][base+b][q]) * int'($signed(cfg_wrows[a][b]));
          end
        end
        if (acc <= 0) made[n].chan[q] = '0;
        else if ((acc >> FRAC_W) > 255) made[n].chan[q] = 8'hFF;
        else made[n].chan[q] = CH_W'(acc >> FRAC_W);
      end
      made[n].row = ROW_W'(r - rad);
      made[n].col = OUT_COL_W'(c - rad);
      n++;
    end
    // border pixels come straight out as zero
    if (r < rad || r + rad >= h || c < rad || c + rad >= w) begin
      made[n] = '0;
      made[n].row = ROW_W'(r);
      made[n].col = OUT_COL_W'(c);
      n++;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_outputs.push_back(made[i]);
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  function automatic bit sender_waits();
    case (load_mode)
      LOAD_SENDER: return $urandom_range(99) < 80;
      LOAD_BOTH:   return $urandom_range(99) < 12;
      default:     return 1'b0;
    endcase
  endfunction

  // APB write: setup, access, then idle with psel low, so back-to-back writes
  // never touch psel twice in one step. The shadow copy follows the write.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(int'(idx) * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:   cfg_width  = value[FW_W-1:0];
      REG_FRAME_HEIGHT:  cfg_height = value[FH_W-1:0];
      REG_KERNEL_RADIUS: cfg_radius = value[RAD_W-1:0];
      default: cfg_wrows[int'(idx) - int'(REG_WEIGHT_ROW0)] = value[NUM_WROWS*W_BITS-1:0];
    endcase
  endtask

  // Drops valid, waits for every owed result, then lets pixels that owe
  // nothing clear the pipeline before the block is treated as idle.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One pixel transfer. Valid stays up across back-to-back pixels.
  task automatic push_pixel(pix_t p);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    chan0_in <= p[0];
    chan1_in <= p[1];
    chan2_in <= p[2];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: back-pressure follows the current traffic shape.
  always @(posedge clk) begin
    case (load_mode)
      LOAD_RECEIVER: out_ready <= ($urandom_range(99) >= 80);
      LOAD_BOTH:     out_ready <= ($urandom_range(99) >= 12);
      default:       out_ready <= 1'b1;
    endcase
  end

  // Result checker: every transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result at row %0d col %0d", out_row, out_col);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("chan0_out", want.chan[0], chan0_out);
        check_field("chan1_out", want.chan[1], chan1_out);
        check_field("chan2_out", want.chan[2], chan2_out);
        check_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  // Main sequence: reset, directed script, then randomized phases that each
  // pick a new geometry and kernel and a new traffic shape.
  initial begin
    load_mode_e  schedule [4] = '{LOAD_NONE, LOAD_SENDER, LOAD_RECEIVER, LOAD_BOTH};
    script_row_t row;
    reg_idx_t    ri;
    wrow_t       wr;
    logic [CFG_DW-1:0] val;
    pix_t        p;
    int          sent;
    int          n_items;
    int          pause_at;
    int          ph;

    // shadow state after reset: identity at row 1 col 1, stores cleared
    foreach (cfg_wrows[i]) cfg_wrows[i] = '0;
    cfg_wrows[1][1] = W_ONE;
    foreach (line_copy[i, j]) line_copy[i][j] = '0;
    foreach (win_copy[i, j]) win_copy[i][j] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part; in_ready stays low through the line store clearing pass
    foreach (script_tab[i]) begin
      row = script_tab[i];
      if (row.kind == STEP_WRITE) begin
        settle_outputs();
        write_reg(row.idx, row.data);
      end else begin
        filter_pixel(row.pix);
        if (row.typed) pending_outputs[pending_outputs.size()-1] = row.want;
        push_pixel(row.pix);
      end
    end

    // random phases
    sent = 0;
    ph = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_outputs();
      ri = ri.first();
      repeat (ri.num()) begin
        case (ri)
          REG_FRAME_WIDTH: begin
            case ($urandom_range(0, 15))
              0:       val = 64'd0;
              1:       val = 64'd2047;
              2:       val = 64'd1024;
              3:       val = 64'($urandom_range(13, 2047));
              default: val = 64'($urandom_range(1, 12));
            endcase
          end
          REG_FRAME_HEIGHT: begin
            case ($urandom_range(0, 15))
              0:       val = 64'd0;
              1:       val = 64'd8191;
              2:       val = 64'd4096;
              3:       val = 64'($urandom_range(0, 8191));
              default: val = 64'($urandom_range(1, 10));
            endcase
          end
          REG_KERNEL_RADIUS: val = 64'($urandom_range(0, 3));
          default: begin
            // mostly modest weights so sums land inside 0..255
            for (int j = 0; j < NUM_WROWS; j++) begin
              case ($urandom_range(0, 9))
                0:       wr[j] = W_BITS'($urandom);
                1:       wr[j] = 12'h7FF;
                2:       wr[j] = 12'h800;
                3:       wr[j] = '0;
                4:       wr[j] = W_ONE;
                default: wr[j] = W_BITS'(int'($urandom_range(0, 64)) - 24);
              endcase
            end
            val = 64'(wr);
          end
        endcase
        write_reg(ri, val);
        ri = ri.next();
      end
      load_mode = schedule[ph % 4];
      n_items = $urandom_range(50, 130);
      pause_at = $urandom_range(0, n_items - 1);
      for (int i = 0; i < n_items; i++) begin
        // hold off until the block has handed over everything it owes
        if (i == pause_at) begin
          while (pending_outputs.size() != 0) begin
            in_valid <= 1'b0;
            @(posedge clk);
          end
        end
        for (int q = 0; q < CHANNELS; q++) begin
          case ($urandom_range(0, 9))
            0:       p[q] = 8'h00;
            1:       p[q] = 8'hFF;
            default: p[q] = CH_W'($urandom);
          endcase
        end
        filter_pixel(p);
        push_pixel(p);
        sent++;
      end
      ph++;
    end

    settle_outputs();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
